### hw/rtl/serial_deframer_crc16_check_core_macros.svh
// assertion macros used by sdfc_checker
`ifndef SERIAL_DEFRAMER_CRC16_CHECK_CORE_MACROS_SVH
`define SERIAL_DEFRAMER_CRC16_CHECK_CORE_MACROS_SVH

// same-cycle implication, skipped while dis is high
`define SDFC_ASSERT_IMPL(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("sdfc assertion failed");

// next-cycle implication, skipped while dis is high
`define SDFC_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("sdfc assertion failed");

`endif

### hw/rtl/sdfc_pkg.sv
package sdfc_pkg;

  localparam logic [7:0] SYNC0  = 8'hAA;
  localparam logic [7:0] SYNC1  = 8'h55;
  localparam logic [7:0] TRAIL0 = 8'h0D;
  localparam logic [7:0] TRAIL1 = 8'h0A;

  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [15:0] CRC_INIT      = 16'h0000;
  localparam logic [15:0] MAX_LEN_RESET = 16'd4096;

  localparam int ADDR_W = 3;
  localparam logic REG_MAX_LEN = 1'b0;

  typedef enum logic [9:0] {
    PH_HUNT0   = 10'b00_0000_0001,
    PH_HUNT1   = 10'b00_0000_0010,
    PH_TYPE    = 10'b00_0000_0100,
    PH_LENLO   = 10'b00_0000_1000,
    PH_LENHI   = 10'b00_0001_0000,
    PH_PAYLOAD = 10'b00_0010_0000,
    PH_CRCLO   = 10'b00_0100_0000,
    PH_CRCHI   = 10'b00_1000_0000,
    PH_TRL0    = 10'b01_0000_0000,
    PH_TRL1    = 10'b10_0000_0000
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_CRC_ERR     = 2'd1,
    ST_TRAILER_ERR = 2'd2,
    ST_LEN_ERR     = 2'd3
  } status_t;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  frame_type;
    logic [15:0] payload_len;
    logic [1:0]  status;
    logic        last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } result_req_t;

endpackage

### hw/rtl/sdfc_if.sv
interface sdfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sdfc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic [7:0]  frame_type;
  logic [15:0] payload_len;
  logic [1:0]  status;
  logic        last;

  modport source (
    output valid, output kind, output data_byte, output frame_type,
    output payload_len, output status, output last, input ready
  );
  modport sink (
    input valid, input kind, input data_byte, input frame_type,
    input payload_len, input status, input last, output ready
  );
endinterface

### hw/rtl/sdfc_crc16.sv
module sdfc_crc16 (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ sdfc_pkg::CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

### hw/rtl/sdfc_ctrl.sv
module sdfc_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     take,
  input  logic [7:0]               rx_byte,
  input  logic [15:0]              max_len,
  output sdfc_pkg::result_req_t    req
);

  sdfc_pkg::phase_t phase, phase_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  type_reg, type_reg_next;
  logic [15:0] length_reg, length_reg_next;
  logic [15:0] byte_count, byte_count_next;
  logic [15:0] received_crc, received_crc_next;
  logic        trailer_bad, trailer_bad_next;

  logic [15:0] crc_seed;
  logic [15:0] crc_upd;
  logic [15:0] len_full;
  logic [15:0] count_inc;
  logic        trl_bad_now;

  // hunting phases restart the crc from zero
  assign crc_seed = (phase == sdfc_pkg::PH_TYPE || phase == sdfc_pkg::PH_LENLO ||
                     phase == sdfc_pkg::PH_LENHI || phase == sdfc_pkg::PH_PAYLOAD ||
                     (phase == sdfc_pkg::PH_HUNT1 && rx_byte == sdfc_pkg::SYNC1)) ?
                    running_crc : sdfc_pkg::CRC_INIT;

  sdfc_crc16 u_crc (
    .crc_in  (crc_seed),
    .data    (rx_byte),
    .crc_out (crc_upd)
  );

  assign len_full    = {rx_byte, length_reg[7:0]};
  assign count_inc   = byte_count + 16'd1;
  assign trl_bad_now = trailer_bad || (rx_byte != sdfc_pkg::TRAIL1);

  always_comb begin
    phase_next        = phase;
    running_crc_next  = running_crc;
    type_reg_next     = type_reg;
    length_reg_next   = length_reg;
    byte_count_next   = byte_count;
    received_crc_next = received_crc;
    trailer_bad_next  = trailer_bad;

    req.valid           = 1'b0;
    req.res.kind        = sdfc_pkg::KIND_STATUS;
    req.res.data_byte   = 8'h00;
    req.res.frame_type  = type_reg;
    req.res.payload_len = length_reg;
    req.res.status      = sdfc_pkg::ST_OK;
    req.res.last        = 1'b1;

    case (phase)
      sdfc_pkg::PH_HUNT1: begin
        if (rx_byte == sdfc_pkg::SYNC1) begin
          running_crc_next = crc_upd;
          phase_next       = sdfc_pkg::PH_TYPE;
        end else if (rx_byte == sdfc_pkg::SYNC0) begin
          running_crc_next = crc_upd;
        end else begin
          running_crc_next = sdfc_pkg::CRC_INIT;
          phase_next       = sdfc_pkg::PH_HUNT0;
        end
      end
      sdfc_pkg::PH_TYPE: begin
        type_reg_next    = rx_byte;
        running_crc_next = crc_upd;
        phase_next       = sdfc_pkg::PH_LENLO;
      end
      sdfc_pkg::PH_LENLO: begin
        length_reg_next  = {8'h00, rx_byte};
        running_crc_next = crc_upd;
        phase_next       = sdfc_pkg::PH_LENHI;
      end
      sdfc_pkg::PH_LENHI: begin
        length_reg_next  = len_full;
        running_crc_next = crc_upd;
        byte_count_next  = 16'd0;
        if (len_full > max_len) begin
          req.valid           = 1'b1;
          req.res.payload_len = len_full;
          req.res.status      = sdfc_pkg::ST_LEN_ERR;
          running_crc_next    = sdfc_pkg::CRC_INIT;
          phase_next          = sdfc_pkg::PH_HUNT0;
        end else if (len_full == 16'd0) begin
          phase_next = sdfc_pkg::PH_CRCLO;
        end else begin
          phase_next = sdfc_pkg::PH_PAYLOAD;
        end
      end
      sdfc_pkg::PH_PAYLOAD: begin
        running_crc_next  = crc_upd;
        req.valid         = 1'b1;
        req.res.kind      = sdfc_pkg::KIND_DATA;
        req.res.data_byte = rx_byte;
        req.res.last      = 1'b0;
        byte_count_next   = count_inc;
        if (count_inc == length_reg) begin
          phase_next = sdfc_pkg::PH_CRCLO;
        end
      end
      sdfc_pkg::PH_CRCLO: begin
        received_crc_next = {8'h00, rx_byte};
        phase_next        = sdfc_pkg::PH_CRCHI;
      end
      sdfc_pkg::PH_CRCHI: begin
        received_crc_next = {rx_byte, received_crc[7:0]};
        trailer_bad_next  = 1'b0;
        phase_next        = sdfc_pkg::PH_TRL0;
      end
      sdfc_pkg::PH_TRL0: begin
        trailer_bad_next = (rx_byte != sdfc_pkg::TRAIL0);
        phase_next       = sdfc_pkg::PH_TRL1;
      end
      sdfc_pkg::PH_TRL1: begin
        trailer_bad_next = trl_bad_now;
        req.valid        = 1'b1;
        if (trl_bad_now) begin
          req.res.status = sdfc_pkg::ST_TRAILER_ERR;
        end else if (received_crc != running_crc) begin
          req.res.status = sdfc_pkg::ST_CRC_ERR;
        end else begin
          req.res.status = sdfc_pkg::ST_OK;
        end
        running_crc_next = sdfc_pkg::CRC_INIT;
        phase_next       = sdfc_pkg::PH_HUNT0;
      end
      default: begin
        // first sync byte, also any unused code
        if (rx_byte == sdfc_pkg::SYNC0) begin
          running_crc_next = crc_upd;
          phase_next       = sdfc_pkg::PH_HUNT1;
        end else begin
          running_crc_next = sdfc_pkg::CRC_INIT;
          phase_next       = sdfc_pkg::PH_HUNT0;
        end
      end
    endcase

    req.valid = req.valid && take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= sdfc_pkg::PH_HUNT0;
      running_crc  <= sdfc_pkg::CRC_INIT;
      type_reg     <= 8'h00;
      length_reg   <= 16'd0;
      byte_count   <= 16'd0;
      received_crc <= 16'd0;
      trailer_bad  <= 1'b0;
    end else if (take) begin
      phase        <= phase_next;
      running_crc  <= running_crc_next;
      type_reg     <= type_reg_next;
      length_reg   <= length_reg_next;
      byte_count   <= byte_count_next;
      received_crc <= received_crc_next;
      trailer_bad  <= trailer_bad_next;
    end
  end

endmodule

### hw/rtl/sdfc_out_stage.sv
module sdfc_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  sdfc_pkg::result_req_t req,
  output logic                  free,
  sdfc_out_if.source            res
);

  logic              valid;
  sdfc_pkg::result_t data;

  // a slot is open when none is held or the held request leaves this cycle
  assign free = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && req.valid) begin
      data <= req.res;
    end
  end

  assign res.valid       = valid;
  assign res.kind        = data.kind;
  assign res.data_byte   = data.data_byte;
  assign res.frame_type  = data.frame_type;
  assign res.payload_len = data.payload_len;
  assign res.status      = data.status;
  assign res.last        = data.last;

endmodule

### hw/rtl/serial_deframer_crc16_check_core.sv
// channel  | role   | payload
// ---------+--------+-------------------------------------------------------
// rx       | sink   | rx_byte
// res      | source | kind, data_byte, frame_type, payload_len, status, last
// apb      | slave  | max_payload_len at byte address 0
//
// one byte is taken per cycle while rx.ready is high; its request, if any, appears in the
// output register in the next cycle. the whole byte step (one-byte crc update and phase decode) sits between
// the deframer state and the output register
// rx.ready drops only while a request is held in the output register and
// res.ready is low
// rst is synchronous: hunting for sync, max_payload_len back to 4096
module serial_deframer_crc16_check_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sdfc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  sdfc_in_if.sink                     rx,
  sdfc_out_if.source                  res
);

  logic [15:0]           max_len;
  logic                  free;
  logic                  take;
  sdfc_pkg::result_req_t req;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == sdfc_pkg::REG_MAX_LEN) ? {16'h0000, max_len} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= sdfc_pkg::MAX_LEN_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == sdfc_pkg::REG_MAX_LEN) begin
      max_len <= pwdata[15:0];
    end
  end

  assign rx.ready = free;
  assign take     = rx.valid && free;

  sdfc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx.rx_byte),
    .max_len (max_len),
    .req     (req)
  );

  sdfc_out_stage u_out (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .free (free),
    .res  (res)
  );

endmodule

### hw/rtl/sdfc_checker.sv
`include "serial_deframer_crc16_check_core_macros.svh"

module sdfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        rx_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic        kind,
  input logic [7:0]  data_byte,
  input logic [7:0]  frame_type,
  input logic [15:0] payload_len,
  input logic [1:0]  status,
  input logic        last
);

  logic [35:0] fields;

  assign fields = {kind, data_byte, frame_type, payload_len, status, last};

  `SDFC_ASSERT_NEXT(a_rst_clears, clk, 1'b0, rst, !res_valid)
  `SDFC_ASSERT_NEXT(a_stall_holds, clk, rst, res_valid && !res_ready, res_valid && $stable(fields))
  `SDFC_ASSERT_IMPL(a_stall_backpressure, clk, rst, res_valid && !res_ready, !rx_ready)
  `SDFC_ASSERT_IMPL(a_data_fields, clk, rst, res_valid && kind == sdfc_pkg::KIND_DATA, status == sdfc_pkg::ST_OK && !last)
  `SDFC_ASSERT_IMPL(a_status_fields, clk, rst, res_valid && kind == sdfc_pkg::KIND_STATUS, last && data_byte == 8'h00)

endmodule

bind serial_deframer_crc16_check_core sdfc_checker u_sdfc_checker (
  .clk         (clk),
  .rst         (rst),
  .rx_ready    (rx.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .kind        (res.kind),
  .data_byte   (res.data_byte),
  .frame_type  (res.frame_type),
  .payload_len (res.payload_len),
  .status      (res.status),
  .last        (res.last)
);

### tb/serial_deframer_crc16_check_core_checker.sv
`timescale 1ns / 1ps
module serial_deframer_crc16_check_core_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [sdfc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  sdfc_in_if                          rx,
  sdfc_out_if                         res,
  output int                          fail_count,
  output int                          pending,
  output logic [15:0]                 crc_so_far
);

  localparam int AW = sdfc_pkg::ADDR_W;
  localparam logic [AW-1:0] MAX_LEN_ADDR = AW'(4 * sdfc_pkg::REG_MAX_LEN);

  logic [15:0]        max_len;
  sdfc_pkg::phase_t   ph;
  logic [15:0]        crc_acc;
  logic [7:0]         type_acc;
  logic [15:0]        len_acc;
  logic [15:0]        count_acc;
  logic [15:0]        crc_rx;
  logic               trailer_bad;
  sdfc_pkg::result_t  deframed_q[$];
  int                 mismatches = 0;
  int                 outstanding = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;
  assign crc_so_far = crc_acc;

  function automatic logic [15:0] crc16_xmodem_byte(input logic [15:0] crc,
                                                    input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ sdfc_pkg::CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic void push_request(input sdfc_pkg::kind_t k, input logic [7:0] d,
                                       input sdfc_pkg::status_t s);
    sdfc_pkg::result_t r;
    r.kind        = k;
    r.data_byte   = d;
    r.frame_type  = type_acc;
    r.payload_len = len_acc;
    r.status      = s;
    r.last        = (k == sdfc_pkg::KIND_STATUS);
    deframed_q    = {deframed_q, r};
  endfunction

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    case (ph)
      sdfc_pkg::PH_HUNT1: begin
        if (b == sdfc_pkg::SYNC1) begin
          crc_acc = crc16_xmodem_byte(crc_acc, b);
          ph = sdfc_pkg::PH_TYPE;
        end else if (b == sdfc_pkg::SYNC0) begin
          crc_acc = crc16_xmodem_byte(sdfc_pkg::CRC_INIT, b);
        end else begin
          crc_acc = sdfc_pkg::CRC_INIT;
          ph = sdfc_pkg::PH_HUNT0;
        end
      end
      sdfc_pkg::PH_TYPE: begin
        type_acc = b;
        crc_acc = crc16_xmodem_byte(crc_acc, b);
        ph = sdfc_pkg::PH_LENLO;
      end
      sdfc_pkg::PH_LENLO: begin
        len_acc = {8'h00, b};
        crc_acc = crc16_xmodem_byte(crc_acc, b);
        ph = sdfc_pkg::PH_LENHI;
      end
      sdfc_pkg::PH_LENHI: begin
        len_acc = {b, len_acc[7:0]};
        crc_acc = crc16_xmodem_byte(crc_acc, b);
        count_acc = '0;
        if (len_acc > max_len) begin
          push_request(sdfc_pkg::KIND_STATUS, 8'h00, sdfc_pkg::ST_LEN_ERR);
          crc_acc = sdfc_pkg::CRC_INIT;
          ph = sdfc_pkg::PH_HUNT0;
        end else if (len_acc == 16'd0) begin
          ph = sdfc_pkg::PH_CRCLO;
        end else begin
          ph = sdfc_pkg::PH_PAYLOAD;
        end
      end
      sdfc_pkg::PH_PAYLOAD: begin
        crc_acc = crc16_xmodem_byte(crc_acc, b);
        push_request(sdfc_pkg::KIND_DATA, b, sdfc_pkg::ST_OK);
        count_acc = count_acc + 16'd1;
        if (count_acc == len_acc) ph = sdfc_pkg::PH_CRCLO;
      end
      sdfc_pkg::PH_CRCLO: begin
        crc_rx = {8'h00, b};
        ph = sdfc_pkg::PH_CRCHI;
      end
      sdfc_pkg::PH_CRCHI: begin
        crc_rx = {b, crc_rx[7:0]};
        trailer_bad = 1'b0;
        ph = sdfc_pkg::PH_TRL0;
      end
      sdfc_pkg::PH_TRL0: begin
        trailer_bad = (b != sdfc_pkg::TRAIL0);
        ph = sdfc_pkg::PH_TRL1;
      end
      sdfc_pkg::PH_TRL1: begin
        if (b != sdfc_pkg::TRAIL1) trailer_bad = 1'b1;
        // a broken trailer wins over a crc mismatch
        if (trailer_bad) begin
          push_request(sdfc_pkg::KIND_STATUS, 8'h00, sdfc_pkg::ST_TRAILER_ERR);
        end else if (crc_rx != crc_acc) begin
          push_request(sdfc_pkg::KIND_STATUS, 8'h00, sdfc_pkg::ST_CRC_ERR);
        end else begin
          push_request(sdfc_pkg::KIND_STATUS, 8'h00, sdfc_pkg::ST_OK);
        end
        crc_acc = sdfc_pkg::CRC_INIT;
        ph = sdfc_pkg::PH_HUNT0;
      end
      default: begin
        if (b == sdfc_pkg::SYNC0) begin
          crc_acc = crc16_xmodem_byte(sdfc_pkg::CRC_INIT, b);
          ph = sdfc_pkg::PH_HUNT1;
        end else begin
          crc_acc = sdfc_pkg::CRC_INIT;
          ph = sdfc_pkg::PH_HUNT0;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    sdfc_pkg::result_t got;
    sdfc_pkg::result_t want;
    if (rst) begin
      max_len     = sdfc_pkg::MAX_LEN_RESET;
      ph          = sdfc_pkg::PH_HUNT0;
      crc_acc     = sdfc_pkg::CRC_INIT;
      type_acc    = '0;
      len_acc     = '0;
      count_acc   = '0;
      crc_rx      = '0;
      trailer_bad = 1'b0;
      deframed_q.delete();
    end else begin
      if (res.valid && res.ready) begin
        got.kind        = res.kind;
        got.data_byte   = res.data_byte;
        got.frame_type  = res.frame_type;
        got.payload_len = res.payload_len;
        got.status      = res.status;
        got.last        = res.last;
        if (deframed_q.size() == 0) begin
          $error("request with nothing expected: kind %0h, data_byte %0h, status %0h",
                 got.kind, got.data_byte, got.status);
          mismatches++;
        end else begin
          want = deframed_q.pop_front();
          compare_field("kind", 16'(want.kind), 16'(got.kind));
          compare_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
          compare_field("frame_type", 16'(want.frame_type), 16'(got.frame_type));
          compare_field("payload_len", want.payload_len, got.payload_len);
          compare_field("status", 16'(want.status), 16'(got.status));
          compare_field("last", 16'(want.last), 16'(got.last));
        end
      end
      if (psel && penable && pwrite && pready && paddr == MAX_LEN_ADDR) begin
        max_len = pwdata[15:0];
      end
      if (rx.valid && rx.ready) deframe_byte(rx.rx_byte);
    end
    outstanding = deframed_q.size();
  end

endmodule

### tb/serial_deframer_crc16_check_core_tb.sv
`timescale 1ns / 1ps
module serial_deframer_crc16_check_core_tb;

  localparam int CYCLE_LIMIT = 500000;
  localparam int RAND_BYTES  = 1700;
  localparam int PHASES      = 6;
  localparam int AW          = sdfc_pkg::ADDR_W;
  localparam logic [AW-1:0] MAX_LEN_ADDR = AW'(4 * sdfc_pkg::REG_MAX_LEN);

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_t;

  logic          clk;
  logic          rst;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [AW-1:0] paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  sdfc_in_if  rx_ch ();
  sdfc_out_if res_ch ();

  int          fail_count;
  int          pending;
  logic [15:0] chk_crc;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          sent = 0;
  logic [15:0] cur_max = sdfc_pkg::MAX_LEN_RESET;

  serial_deframer_crc16_check_core DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rx      (rx_ch),
    .res     (res_ch)
  );

  serial_deframer_crc16_check_core_checker frame_check (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .rx         (rx_ch),
    .res        (res_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .crc_so_far (chk_crc)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : receiver
    stall_t mode;
    int     span;
    int     tick;
    tick = 0;
    res_ch.ready = 1'b0;
    forever begin
      mode = stall_t'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          STALL_NONE:     res_ch.ready <= 1'b1;
          STALL_RANDOM:   res_ch.ready <= ($urandom_range(0, 3) != 0);
          STALL_PERIODIC: res_ch.ready <= tick[2];
          default:        res_ch.ready <= (tick % 12 == 0);
        endcase
      end
    end
  end

  function automatic logic [7:0] other_than(input logic [7:0] x);
    logic [7:0] b;
    b = 8'($urandom_range(0, 254));
    return (b >= x) ? b + 8'd1 : b;
  endfunction

  // one byte request, with bursts and random gaps in between
  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8)
                                               : $urandom_range(20, 150);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    sent++;
  endtask

  task automatic settle();
    rx_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_max_len(input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_LEN_ADDR;
    pwdata  <= {16'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_max = value;
  endtask

  // crc bytes are taken from the running crc of the bytes actually parsed
  task automatic send_frame(input logic [7:0] ftype, input logic [15:0] flen, input int cut,
                            input bit bad_crc, input logic [1:0] trl_err);
    logic [15:0] crc;
    send_byte(sdfc_pkg::SYNC0);
    send_byte(sdfc_pkg::SYNC1);
    send_byte(ftype);
    send_byte(flen[7:0]);
    send_byte(flen[15:8]);
    if (flen > cur_max) return;
    for (int i = 0; i < int'(flen); i++) begin
      if (i == cut) return;
      send_byte(8'($urandom_range(0, 255)));
    end
    crc = chk_crc ^ (bad_crc ? 16'($urandom_range(1, 16'hFFFF)) : 16'h0000);
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
    send_byte(trl_err[0] ? other_than(sdfc_pkg::TRAIL0) : sdfc_pkg::TRAIL0);
    send_byte(trl_err[1] ? other_than(sdfc_pkg::TRAIL1) : sdfc_pkg::TRAIL1);
  endtask

  task automatic stream_frames(input int nbytes);
    int start;
    int pick;
    int len;
    int cap;
    int cut;
    start = sent;
    while (sent - start < nbytes) begin
      repeat ($urandom_range(0, 2)) begin
        pick = $urandom_range(0, 9);
        send_byte(pick < 3 ? sdfc_pkg::SYNC0 : 8'($urandom_range(0, 255)));
      end
      cap  = (int'(cur_max) < 24) ? int'(cur_max) : 24;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        len = $urandom_range(0, cap);
      end else if (pick < 72) begin
        len = (int'(cur_max) <= 64) ? int'(cur_max) : $urandom_range(25, 64);
      end else if (pick < 97) begin
        len = (cur_max < 16'hFFFF) ? $urandom_range(int'(cur_max) + 1, 16'hFFFF)
                                   : $urandom_range(0, cap);
      end else begin
        len = $urandom_range(0, (int'(cur_max) < 300) ? int'(cur_max) : 300);
      end
      cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len) : len;
      send_frame(8'($urandom_range(0, 255)), 16'(len), cut,
                 $urandom_range(0, 9) == 0,
                 ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : 2'b00);
      if ($urandom_range(0, 29) == 0) settle();
    end
  endtask

  initial begin : stimulus
    logic [15:0] max_settings[PHASES-1];
    max_settings = '{16'd0, 16'hFFFF, 16'd1, 16'd20, 16'd0};
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // sync restart into a good one-byte frame, then crc and trailer both bad,
    // then the longest length field
    send_byte(sdfc_pkg::SYNC0);
    send_frame(8'hFF, 16'd1, 1, 1'b0, 2'b00);
    send_frame(8'h00, 16'd0, 0, 1'b1, 2'b11);
    send_frame(8'h5A, 16'hFFFF, 0, 1'b0, 2'b00);
    stream_frames(RAND_BYTES / PHASES);

    for (int p = 0; p < PHASES - 1; p++) begin
      settle();
      write_max_len(p == PHASES - 2 ? 16'($urandom_range(2, 200)) : max_settings[p]);
      stream_frames(RAND_BYTES / PHASES);
    end

    settle();
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
